### design/pcrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrc_pkg: shared types, constants and functions
// Register indexes, queue sizing, word and configuration structs, and the
// bytewise CRC-64 update.
// ----------------------------------------------------------------------------
package pcrc_pkg;

    localparam int CRC_W      = 64;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_POLYNOMIAL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLECT_INPUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLECT_OUTPUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_XOR      = 3'd4;

    localparam logic [CRC_W-1:0] POLY_RESET = 64'h42F0_E1EB_A9EA_3693;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } pcrc_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } pcrc_qstat_t;

    typedef struct packed {
        logic [CRC_W-1:0] polynomial;
        logic [CRC_W-1:0] initial_value;
        logic             reflect_output;
        logic [CRC_W-1:0] final_xor;
    } pcrc_cfg_t;

    function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int k = 0; k < BYTE_W; k++) begin
            r[k] = v[BYTE_W-1-k];
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] rev64(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int k = 0; k < CRC_W; k++) begin
            r[k] = v[CRC_W-1-k];
        end
        return r;
    endfunction

    // MSB-first absorb of one byte, eight shift-and-xor steps
    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ poly;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### design/pcrc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrc_front: input side
// Takes words from the input channel, applies input byte reflection and
// pushes them into the queue.
// ----------------------------------------------------------------------------
module pcrc_front (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_last_byte,
    input  logic                 reflect_input,
    input  pcrc_pkg::pcrc_qstat_t qstat,
    output logic                 push,
    output pcrc_pkg::pcrc_item_t push_item
);
    import pcrc_pkg::*;

    assign s_ready = !qstat.full;
    assign push    = s_valid && !qstat.full;

    always_comb begin
        push_item.data_byte = reflect_input ? rev8(s_data_byte) : s_data_byte;
        push_item.last_byte = s_last_byte;
    end

endmodule

### design/pcrc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrc_queue: two-entry word queue
// Decouples the input side from the CRC engine.
// ----------------------------------------------------------------------------
module pcrc_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  pcrc_pkg::pcrc_item_t  push_item,
    input  logic                  pop,
    output pcrc_pkg::pcrc_item_t  head_item,
    output pcrc_pkg::pcrc_qstat_t qstat
);
    import pcrc_pkg::*;

    pcrc_item_t        slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item   = slot_reg[rd_ptr_reg];
    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));

endmodule

### design/pcrc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrc_back: CRC engine
// Pops words, folds each byte into the running CRC and, on the last byte,
// loads the finished CRC into the output register.
// ----------------------------------------------------------------------------
module pcrc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pcrc_pkg::pcrc_cfg_t   cfg,
    input  pcrc_pkg::pcrc_item_t  head_item,
    input  pcrc_pkg::pcrc_qstat_t qstat,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [63:0]           m_crc_value
);
    import pcrc_pkg::*;

    logic [CRC_W-1:0] running_reg, running_next;
    logic             busy_reg,    busy_next;
    logic             out_valid_reg, out_valid_next;
    logic [CRC_W-1:0] out_crc_reg,   out_crc_next;
    logic [CRC_W-1:0] crc_base;
    logic [CRC_W-1:0] crc_new;
    logic             out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign pop      = !qstat.empty && (!head_item.last_byte || out_free);
    assign crc_base = busy_reg ? running_reg : cfg.initial_value;
    assign crc_new  = crc_byte(crc_base, head_item.data_byte, cfg.polynomial);

    always_comb begin
        running_next   = running_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_crc_next   = out_crc_reg;
        if (pop) begin
            running_next = crc_new;
            busy_next    = !head_item.last_byte;
            if (head_item.last_byte) begin
                out_valid_next = 1'b1;
                out_crc_next   = (cfg.reflect_output ? rev64(crc_new) : crc_new)
                                 ^ cfg.final_xor;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        running_reg <= running_next;
        out_crc_reg <= out_crc_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_crc_value = out_crc_reg;

endmodule

### design/programmable_crc64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// programmable_crc64: configurable CRC-64, one message byte per word
// Throughput: one byte per cycle, set by the 8-step XOR network in the engine,
// as long as no finished CRC waits in the output register for m_ready.
// Reset: synchronous active-low; queue and output emptied, registers take
// the ECMA-182 polynomial, zero initial value, no reflection, zero final XOR.
// ----------------------------------------------------------------------------
module programmable_crc64 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_crc_value
);
    import pcrc_pkg::*;

    logic [CRC_W-1:0] polynomial_reg;
    logic [CRC_W-1:0] initial_value_reg;
    logic             reflect_input_reg;
    logic             reflect_output_reg;
    logic [CRC_W-1:0] final_xor_reg;

    pcrc_cfg_t   cfg;
    pcrc_qstat_t qstat;
    pcrc_item_t  push_item;
    pcrc_item_t  head_item;
    logic        push;
    logic        pop;
    logic        cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            polynomial_reg     <= POLY_RESET;
            initial_value_reg  <= '0;
            reflect_input_reg  <= 1'b0;
            reflect_output_reg <= 1'b0;
            final_xor_reg      <= '0;
        end else if (cfg_wr) begin
            case (cfg_index)
                CFG_POLYNOMIAL:     polynomial_reg     <= cfg_data;
                CFG_INITIAL_VALUE:  initial_value_reg  <= cfg_data;
                CFG_REFLECT_INPUT:  reflect_input_reg  <= cfg_data[0];
                CFG_REFLECT_OUTPUT: reflect_output_reg <= cfg_data[0];
                CFG_FINAL_XOR:      final_xor_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.polynomial     = polynomial_reg;
        cfg.initial_value  = initial_value_reg;
        cfg.reflect_output = reflect_output_reg;
        cfg.final_xor      = final_xor_reg;
    end

    pcrc_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .reflect_input (reflect_input_reg),
        .qstat         (qstat),
        .push          (push),
        .push_item     (push_item)
    );

    pcrc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    pcrc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .head_item   (head_item),
        .qstat       (qstat),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_crc_value (m_crc_value)
    );

    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(qstat.full && qstat.empty))
        else $error("queue both full and empty");

    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && qstat.empty) |=> !qstat.empty)
        else $error("pushed word lost");

    a_bad_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr && cfg_index != CFG_POLYNOMIAL && cfg_index != CFG_INITIAL_VALUE
         && cfg_index != CFG_REFLECT_INPUT && cfg_index != CFG_REFLECT_OUTPUT
         && cfg_index != CFG_FINAL_XOR)
        |=> ($stable(polynomial_reg) && $stable(initial_value_reg)
             && $stable(final_xor_reg)))
        else $error("write to unknown index changed a register");

endmodule

### tb/programmable_crc64_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// programmable_crc64_tb: self-checking bench for the configurable CRC-64
// Streams message bytes into the block under a range of CRC settings and
// compares every finished CRC word with a bit-serial software CRC. A short
// directed table with the standard check strings comes first, then random
// messages under random settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
module programmable_crc64_tb;
    import pcrc_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int TOTAL_BYTES   = 1425;
    localparam int DIR_ROWS      = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_FINAL_XOR + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CRC_W-1:0]       value;
        logic                   last;
        bit                     known;
        logic [CRC_W-1:0]       crc;
    } crc_row_t;

    typedef struct {
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] preset;
        logic [CRC_W-1:0] xorout;
        logic             refl_in;
        logic             refl_out;
    } crc_setup_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CRC_W-1:0]     cfg_data    = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_data_byte = '0;
    logic                 s_last_byte = 1'b0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [CRC_W-1:0]     m_crc_value;

    crc_setup_t       crc_cfg;
    logic [CRC_W-1:0] crc_run;
    bit               crc_busy;
    logic [CRC_W-1:0] crc_expq[$];
    int               mismatches  = 0;
    int               bytes_sent  = 0;
    int               ready_hold  = 0;
    bit               quiet       = 1'b0;

    crc_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_BYTE, '0, 64'h00, 1'b1, 1'b1, 64'h0},
        '{ROW_BYTE, '0, 64'h01, 1'b1, 1'b1, POLY_RESET},
        '{ROW_BYTE, '0, 64'h31, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h32, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h33, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h34, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h35, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h36, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h37, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h38, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h39, 1'b1, 1'b1, 64'h6C40_DF5F_0B49_7347},
        // reflected variant of the same polynomial, all-ones preset and xor
        '{ROW_CFG, CFG_INITIAL_VALUE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
        '{ROW_CFG, CFG_REFLECT_INPUT, 64'h1, 1'b0, 1'b0, 64'h0},
        '{ROW_CFG, CFG_REFLECT_OUTPUT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
        '{ROW_CFG, CFG_FINAL_XOR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h31, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h32, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h33, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h34, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h35, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h36, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h37, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h38, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h39, 1'b1, 1'b1, 64'h995D_C9BB_DF19_39FA},
        // zero polynomial: every byte shifts out, CRC stays zero
        '{ROW_CFG, CFG_POLYNOMIAL, 64'h0, 1'b0, 1'b0, 64'h0},
        '{ROW_CFG, CFG_INITIAL_VALUE, 64'h0, 1'b0, 1'b0, 64'h0},
        '{ROW_CFG, CFG_REFLECT_INPUT, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0, 64'h0},
        '{ROW_CFG, CFG_REFLECT_OUTPUT, 64'h0, 1'b0, 1'b0, 64'h0},
        '{ROW_CFG, CFG_FINAL_XOR, 64'h0, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'hFF, 1'b1, 1'b1, 64'h0},
        '{ROW_CFG, CFG_POLYNOMIAL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
        '{ROW_CFG, CFG_FINAL_XOR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
        // unmapped indexes must be dropped
        '{ROW_CFG, CFG_UNUSED_LO, 64'h0, 1'b0, 1'b0, 64'h0},
        '{ROW_CFG, CFG_UNUSED_HI, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h80, 1'b1, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h7F, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'h55, 1'b1, 1'b0, 64'h0},
        '{ROW_CFG, CFG_INITIAL_VALUE, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 64'h0},
        '{ROW_CFG, CFG_REFLECT_OUTPUT, 64'h1, 1'b0, 1'b0, 64'h0},
        '{ROW_BYTE, '0, 64'hAA, 1'b1, 1'b0, 64'h0}
    };

    programmable_crc64 DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_crc_value (m_crc_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [CRC_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return POLY_RESET;
            3: return 64'd1 << $urandom_range(0, CRC_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // bit-serial CRC; returns 1 when the byte closes a message
    function automatic bit crc_take_byte(input logic [BYTE_W-1:0] b, input logic l,
                                         output logic [CRC_W-1:0] crc_out);
        logic [BYTE_W-1:0] d;
        logic [CRC_W-1:0]  c;
        logic              fb;
        crc_out = '0;
        if (!crc_busy) crc_run = crc_cfg.preset;
        d = b;
        if (crc_cfg.refl_in) d = {<<{b}};
        c = crc_run;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            fb = c[CRC_W-1] ^ d[k];
            c  = c << 1;
            if (fb) c = c ^ crc_cfg.poly;
        end
        crc_run  = c;
        crc_busy = 1'b1;
        if (!l) return 1'b0;
        crc_out = c;
        if (crc_cfg.refl_out) crc_out = {<<{c}};
        crc_out  = crc_out ^ crc_cfg.xorout;
        crc_run  = crc_cfg.preset;
        crc_busy = 1'b0;
        return 1'b1;
    endfunction

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic l, input bit known,
                             input logic [CRC_W-1:0] typed);
        int               gap;
        logic [CRC_W-1:0] crc;
        gap = pick_gap();
        cfg_valid <= 1'b0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= l;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (crc_take_byte(b, l, crc)) crc_expq.push_back(known ? typed : crc);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CRC_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_POLYNOMIAL: crc_cfg.poly = val;
            CFG_INITIAL_VALUE: begin
                crc_cfg.preset = val;
                if (!crc_busy) crc_run = val;
            end
            CFG_REFLECT_INPUT: crc_cfg.refl_in = val[0];
            CFG_REFLECT_OUTPUT: crc_cfg.refl_out = val[0];
            CFG_FINAL_XOR: crc_cfg.xorout = val;
            default: ;
        endcase
    endtask

    // drain: no byte in flight, every CRC word returned, pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        while (crc_expq.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : crc_monitor
        logic [CRC_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (crc_expq.size() == 0) begin
                mismatches++;
                $display("%0t: crc_value expected none got %h", $time, m_crc_value);
            end else begin
                want = crc_expq.pop_front();
                if (m_crc_value !== want) begin
                    mismatches++;
                    $display("%0t: crc_value expected %h got %h", $time, want,
                             m_crc_value);
                end
            end
        end
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            ready_hold <= pick_gap();
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        bit prev_cfg;
        int n_msgs;
        int len;
        int r;
        crc_cfg.poly     = POLY_RESET;
        crc_cfg.preset   = '0;
        crc_cfg.xorout   = '0;
        crc_cfg.refl_in  = 1'b0;
        crc_cfg.refl_out = 1'b0;
        crc_run          = '0;
        crc_busy         = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        prev_cfg = 1'b1;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                if (!prev_cfg) settle();
                cfg_write(dir_rows[i].index, dir_rows[i].value);
            end else begin
                push_byte(dir_rows[i].value[BYTE_W-1:0], dir_rows[i].last,
                          dir_rows[i].known, dir_rows[i].crc);
            end
            prev_cfg = (dir_rows[i].kind == ROW_CFG);
        end

        while (bytes_sent < TOTAL_BYTES) begin
            settle();
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1)) cfg_write(CFG_POLYNOMIAL, pick_word());
            if ($urandom_range(0, 1)) cfg_write(CFG_INITIAL_VALUE, pick_word());
            if ($urandom_range(0, 1)) cfg_write(CFG_REFLECT_INPUT, {$urandom, $urandom});
            if ($urandom_range(0, 1)) cfg_write(CFG_REFLECT_OUTPUT, {$urandom, $urandom});
            if ($urandom_range(0, 1)) cfg_write(CFG_FINAL_XOR, pick_word());
            if ($urandom_range(0, 3) == 0)
                cfg_write(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                          {$urandom, $urandom});
            n_msgs = $urandom_range(1, 8);
            repeat (n_msgs) begin
                r = $urandom_range(0, 9);
                if (r < 6) len = $urandom_range(1, 4);
                else if (r < 9) len = $urandom_range(5, 16);
                else len = $urandom_range(17, 64);
                for (int k = 1; k <= len; k++) begin
                    r = $urandom_range(0, 15);
                    push_byte((r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom),
                              k == len, 1'b0, '0);
                end
            end
        end

        quiet = 1'b0;
        settle();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
